>>> sv/assert_macros.svh
// Assertion macros used by the top level of the colour conversion block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while rst is high.
`define CHK_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst is high.
`define CHK_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> sv/ryuv_pkg.sv
// Types and fixed-point constants of the RGB block to YUV 4:2:0 converter.
package ryuv_pkg;

  localparam int PIX_W   = 8;
  localparam int NUM_PIX = 4;
  localparam int FRAC_W  = 16;
  localparam int YSUM_W  = 24;
  localparam int DIFF_W  = 9;
  localparam int PROD_W  = 26;
  localparam int SUM_W   = 11;
  localparam int ACC_W   = 28;
  localparam int COEF_W  = 16;

  // Luma weights in Q16; they add up to exactly one.
  localparam logic [COEF_W-1:0] WY0 = 16'd19595;
  localparam logic [COEF_W-1:0] WY1 = 16'd38470;
  localparam logic [COEF_W-1:0] WY2 = 16'd7471;

  // Chroma scale factors in Q16.
  localparam logic [COEF_W-1:0] KU = 16'd37028;
  localparam logic [COEF_W-1:0] KV = 16'd46727;

  localparam logic [PIX_W-1:0] CHROMA_OFFSET = 8'd128;
  localparam logic [PIX_W-1:0] PIX_MAX       = 8'd255;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } lane_ctrl_t;

  typedef struct packed {
    logic s3_en;
    logic s4_en;
  } merge_ctrl_t;

endpackage

>>> sv/ryuv_lane.sv
// One pixel lane: luma, then the two chroma products, over two register stages.
module ryuv_lane
  import ryuv_pkg::*;
(
  input  logic                     clk,
  input  lane_ctrl_t               ctrl,
  input  pixel_t                   pix,
  output logic [PIX_W-1:0]         luma,
  output logic signed [PROD_W-1:0] prod_u,
  output logic signed [PROD_W-1:0] prod_v
);

  logic [YSUM_W-1:0]        ysum;
  logic [PIX_W-1:0]         y1;
  logic [PIX_W-1:0]         red1;
  logic [PIX_W-1:0]         blue1;
  logic signed [DIFF_W-1:0] diff_u;
  logic signed [DIFF_W-1:0] diff_v;

  // The weights sum to one in Q16, so the integer part never exceeds 255.
  always_comb begin
    ysum = YSUM_W'(pix.red)   * YSUM_W'(WY0)
         + YSUM_W'(pix.green) * YSUM_W'(WY1)
         + YSUM_W'(pix.blue)  * YSUM_W'(WY2);
  end

  always_ff @(posedge clk) begin
    if (ctrl.s1_en) begin
      y1    <= ysum[YSUM_W-1:FRAC_W];
      red1  <= pix.red;
      blue1 <= pix.blue;
    end
  end

  assign diff_u = signed'({1'b0, blue1}) - signed'({1'b0, y1});
  assign diff_v = signed'({1'b0, red1}) - signed'({1'b0, y1});

  always_ff @(posedge clk) begin
    if (ctrl.s2_en) begin
      luma   <= y1;
      prod_u <= PROD_W'(signed'({1'b0, KU})) * PROD_W'(diff_u);
      prod_v <= PROD_W'(signed'({1'b0, KV})) * PROD_W'(diff_v);
    end
  end

endmodule

>>> sv/ryuv_merge.sv
// Merging stage: chains the lanes' chroma products and forms the output beat.
module ryuv_merge
  import ryuv_pkg::*;
(
  input  logic                     clk,
  input  merge_ctrl_t              ctrl,
  input  logic [PIX_W-1:0]         luma_in [NUM_PIX],
  input  logic signed [PROD_W-1:0] prod_u [NUM_PIX],
  input  logic signed [PROD_W-1:0] prod_v [NUM_PIX],
  output logic [PIX_W-1:0]         luma_out [NUM_PIX],
  output logic [PIX_W-1:0]         chroma_u,
  output logic [PIX_W-1:0]         chroma_v
);

  localparam logic [ACC_W-1:0] FracMask = ACC_W'((1 << FRAC_W) - 1);

  // Adds one Q16 product to an integer sum and truncates toward zero.
  function automatic logic signed [SUM_W-1:0] chroma_step(
    input logic signed [SUM_W-1:0]  sum,
    input logic signed [PROD_W-1:0] prod
  );
    logic signed [ACC_W-1:0] acc;
    acc = signed'({{(ACC_W-SUM_W-FRAC_W){sum[SUM_W-1]}}, sum, {FRAC_W{1'b0}}})
        + ACC_W'(prod);
    if (acc[ACC_W-1]) begin
      acc = acc + signed'(FracMask);
    end
    return acc[FRAC_W+SUM_W-1:FRAC_W];
  endfunction

  // Quarter of the sum toward zero, then offset and clamp to a pixel.
  function automatic logic [PIX_W-1:0] chroma_out(input logic signed [SUM_W-1:0] sum);
    logic signed [SUM_W-1:0] adj;
    logic signed [SUM_W-1:0] val;
    adj = sum[SUM_W-1] ? sum + SUM_W'(3) : sum;
    val = (adj >>> 2) + signed'(SUM_W'(CHROMA_OFFSET));
    if (val[SUM_W-1]) begin
      return '0;
    end else if (val > signed'(SUM_W'(PIX_MAX))) begin
      return PIX_MAX;
    end
    return val[PIX_W-1:0];
  endfunction

  logic [PIX_W-1:0]         y3 [NUM_PIX];
  logic signed [SUM_W-1:0]  su3;
  logic signed [SUM_W-1:0]  sv3;
  logic signed [PROD_W-1:0] pu3 [2];
  logic signed [PROD_W-1:0] pv3 [2];
  logic signed [SUM_W-1:0]  su4;
  logic signed [SUM_W-1:0]  sv4;

  // Top row is folded in here, bottom row in the next stage.
  always_ff @(posedge clk) begin
    if (ctrl.s3_en) begin
      y3     <= luma_in;
      su3    <= chroma_step(chroma_step('0, prod_u[0]), prod_u[1]);
      sv3    <= chroma_step(chroma_step('0, prod_v[0]), prod_v[1]);
      pu3[0] <= prod_u[2];
      pu3[1] <= prod_u[3];
      pv3[0] <= prod_v[2];
      pv3[1] <= prod_v[3];
    end
  end

  assign su4 = chroma_step(chroma_step(su3, pu3[0]), pu3[1]);
  assign sv4 = chroma_step(chroma_step(sv3, pv3[0]), pv3[1]);

  always_ff @(posedge clk) begin
    if (ctrl.s4_en) begin
      luma_out <= y3;
      chroma_u <= chroma_out(su4);
      chroma_v <= chroma_out(sv4);
    end
  end

endmodule

>>> sv/rgb_block_to_yuv420_top.sv
// Top level of the RGB 2x2 block to YUV 4:2:0 converter.
//
// Each slave beat carries one 2x2 block of 8-bit RGB pixels; each master beat
// carries the four luma samples of that block and its shared U and V samples.
// Four pixel lanes compute luma and the chroma products side by side, and a
// two-stage merge folds the products into the chroma sums in pixel order.
// An accepted beat moves through the two lane stages and the two merge stages,
// the last of which drives the master side. One block is taken every cycle for
// as long as the master side takes results; the four register stages, each
// with its own valid bit, set that figure. When the receiver stalls, the
// stages fill in turn and s_tready falls only once every stage holds a block,
// so up to four blocks wait inside. Reset empties all stages; no result is
// pending afterwards. There is no tlast or tuser on either side.
module rgb_block_to_yuv420_top
  import ryuv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tl_red, tl_green, tl_blue, tr_red, tr_green, tr_blue,
  // bl_red, bl_green, bl_blue, br_red, br_green, br_blue (8 bits each)
  input  logic [95:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // luma_tl, luma_tr, luma_bl, luma_br, chroma_u, chroma_v (8 bits each)
  output logic [47:0] m_tdata
);

  localparam int PixBits = 3 * PIX_W;

  pixel_t                   pix [NUM_PIX];
  lane_ctrl_t               lane_ctrl;
  merge_ctrl_t              merge_ctrl;
  logic [PIX_W-1:0]         lane_y [NUM_PIX];
  logic signed [PROD_W-1:0] lane_pu [NUM_PIX];
  logic signed [PROD_W-1:0] lane_pv [NUM_PIX];
  logic [PIX_W-1:0]         luma_out [NUM_PIX];
  logic [PIX_W-1:0]         chroma_u;
  logic [PIX_W-1:0]         chroma_v;

  logic v1, v2, v3;
  logic ready2, ready3, ready4;

  // Each stage moves on when it is empty or the stage after it can move.
  assign ready4   = !m_tvalid || m_tready;
  assign ready3   = !v3 || ready4;
  assign ready2   = !v2 || ready3;
  assign s_tready = !v1 || ready2;

  assign lane_ctrl.s1_en  = s_tready && s_tvalid;
  assign lane_ctrl.s2_en  = ready2 && v1;
  assign merge_ctrl.s3_en = ready3 && v2;
  assign merge_ctrl.s4_en = ready4 && v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        v1 <= s_tvalid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
      if (ready4) begin
        m_tvalid <= v3;
      end
    end
  end

  always_comb begin
    for (int p = 0; p < NUM_PIX; p++) begin
      pix[p].red   = s_tdata[p*PixBits +: PIX_W];
      pix[p].green = s_tdata[p*PixBits + PIX_W +: PIX_W];
      pix[p].blue  = s_tdata[p*PixBits + 2*PIX_W +: PIX_W];
    end
  end

  for (genvar g = 0; g < NUM_PIX; g++) begin : g_lane
    ryuv_lane u_lane (
      .clk    (clk),
      .ctrl   (lane_ctrl),
      .pix    (pix[g]),
      .luma   (lane_y[g]),
      .prod_u (lane_pu[g]),
      .prod_v (lane_pv[g])
    );
  end

  ryuv_merge u_merge (
    .clk      (clk),
    .ctrl     (merge_ctrl),
    .luma_in  (lane_y),
    .prod_u   (lane_pu),
    .prod_v   (lane_pv),
    .luma_out (luma_out),
    .chroma_u (chroma_u),
    .chroma_v (chroma_v)
  );

  assign m_tdata = {chroma_v, chroma_u, luma_out[3], luma_out[2], luma_out[1], luma_out[0]};

`include "assert_macros.svh"

  `CHK_IMP(a_full_when_blocked, !s_tready, v1 && v2 && v3 && m_tvalid, "input stalled with a free stage")
  `CHK_NXT(a_accept_fills_s1, s_tvalid && s_tready, v1, "accepted beat did not reach the first stage")
  `CHK_NXT(a_merge_reaches_out, v3 && ready4, m_tvalid, "merged block did not reach the output")
  `CHK_NXT(a_stall_keeps_result, m_tvalid && !m_tready, m_tvalid, "pending result dropped while stalled")

endmodule
